>>> sv/plb_pkg.sv
package plb_pkg;

	localparam int CAPACITY   = 32;
	localparam int DATA_WIDTH = 32;

	localparam int ACT_W  = 3;
	localparam int POS_W  = 6;
	localparam int ITEM_W = 32;
	localparam int IDX_W  = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int CMP_W  = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

	localparam int IN_W  = ((ACT_W + POS_W + ITEM_W + 7) / 8) * 8;
	localparam int OUT_W = ((1 + ITEM_W + POS_W + 7) / 8) * 8;

	typedef logic [DATA_WIDTH-1:0] data_t;

	typedef enum logic [ACT_W-1:0] {
		ACT_GET = 3'd0,
		ACT_SET = 3'd1,
		ACT_INS = 3'd2,
		ACT_REM = 3'd3,
		ACT_CLR = 3'd4
	} act_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_OUT  = 1'b1
	} st_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic rd;
		logic wr_set;
		logic wr_ins;
		logic wr_rem;
		logic clr;
		logic ok;
	} cmd_t;

	// Position checks reported by the datapath.
	typedef struct packed {
		logic pos_in;
		logic ins_ok;
	} status_t;

endpackage

>>> sv/plb_ctrl.sv
module plb_ctrl
	import plb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [ACT_W-1:0] action,
	input  logic             out_ready,
	input  status_t          status,
	output logic             in_ready,
	output logic             out_valid,
	output cmd_t             cmd
);

	st_t state_q;
	st_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_OUT;
					case (act_t'(action))
						ACT_GET: begin
							cmd.rd = status.pos_in;
							cmd.ok = status.pos_in;
						end
						ACT_SET: begin
							cmd.wr_set = status.pos_in;
							cmd.ok     = status.pos_in;
						end
						ACT_INS: begin
							cmd.wr_ins = status.ins_ok;
							cmd.ok     = status.ins_ok;
						end
						ACT_REM: begin
							cmd.wr_rem = status.pos_in;
							cmd.ok     = status.pos_in;
						end
						ACT_CLR: begin
							cmd.clr = 1'b1;
							cmd.ok  = 1'b1;
						end
						default: begin
							cmd.ok = 1'b0;
						end
					endcase
				end
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_write_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_set || cmd.wr_ins || cmd.wr_rem || cmd.clr || cmd.rd) |-> cmd.ok)
		else $error("list modified or read without ok");
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.wr_set, cmd.wr_ins, cmd.wr_rem, cmd.clr, cmd.rd}))
		else $error("more than one list operation at once");
	a_load_then_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (out_valid && !in_ready))
		else $error("result not presented after load");

endmodule

>>> sv/plb_dp.sv
module plb_dp
	import plb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	input  logic [POS_W-1:0]  position,
	input  logic [ITEM_W-1:0] item_value,
	output status_t           status,
	output logic              ok,
	output logic [ITEM_W-1:0] read_value,
	output logic [POS_W-1:0]  length
);

	data_t             cell_q [CAPACITY];
	data_t             cell_d [CAPACITY];
	data_t             item;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  idx;
	logic [POS_W-1:0]  pos_m1;
	logic [CMP_W-1:0]  pos_x;
	logic [CMP_W-1:0]  cnt_x;
	logic              ok_q;
	logic [ITEM_W-1:0] rd_q;

	assign item   = item_value[DATA_WIDTH-1:0];
	assign pos_m1 = position - POS_W'(1);
	assign idx    = pos_m1[IDX_W-1:0];
	assign pos_x  = CMP_W'(position);
	assign cnt_x  = CMP_W'(count_q);

	assign status.pos_in = (position != '0) && (pos_x <= cnt_x);
	assign status.ins_ok = (position != '0) && (pos_x <= cnt_x + CMP_W'(1))
		&& (cnt_x < CMP_W'(CAPACITY));

	// Each cell takes the item, its left neighbor (insert) or its right
	// neighbor (remove); the whole row shifts together.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		data_t left_v;
		data_t right_v;
		if (i > 0) begin : g_left
			assign left_v = cell_q[i-1];
		end else begin : g_left0
			assign left_v = cell_q[i];
		end
		if (i < CAPACITY - 1) begin : g_right
			assign right_v = cell_q[i+1];
		end else begin : g_right_end
			assign right_v = cell_q[i];
		end
		always_comb begin
			cell_d[i] = cell_q[i];
			if (cmd.wr_set && (IDX_W'(i) == idx)) begin
				cell_d[i] = item;
			end else if (cmd.wr_ins) begin
				if (IDX_W'(i) == idx) begin
					cell_d[i] = item;
				end else if (IDX_W'(i) > idx) begin
					cell_d[i] = left_v;
				end
			end else if (cmd.wr_rem && (IDX_W'(i) >= idx)) begin
				cell_d[i] = right_v;
			end
		end
		always_ff @(posedge clk) begin
			cell_q[i] <= cell_d[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ok_q    <= 1'b0;
			rd_q    <= '0;
		end else if (cmd.load) begin
			ok_q <= cmd.ok;
			rd_q <= cmd.rd ? ITEM_W'(cell_q[idx]) : '0;
			if (cmd.clr) begin
				count_q <= '0;
			end else if (cmd.wr_ins) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.wr_rem) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	assign ok         = ok_q;
	assign read_value = rd_q;
	assign length     = POS_W'(count_q);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");
	a_refused_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && !cmd.ok) |=> (count_q == $past(count_q)))
		else $error("refused action changed the length");
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr |=> (count_q == '0))
		else $error("clear left entries");
	a_read_zero_unless_ok: assert property (@(posedge clk) disable iff (!arst_n)
		!ok_q |-> (rd_q == '0))
		else $error("read value nonzero on refused action");

endmodule

>>> sv/positional_list_buffer_core.sv
// Positional list buffer: an ordered list of up to 32 words with positions
// counted from 1. Each input beat carries one action (get, set, insert,
// remove or clear) and produces exactly one output beat carrying ok, the
// word read by a successful get (zero otherwise) and the list length after
// the action. An invalid position, an insert into a full list, or an unknown
// action code changes nothing and returns ok low. The entries sit in a row
// of registers whose cells all shift together, so an insert or remove at any
// position finishes in the cycle the beat is accepted. The block handles one
// item at a time: it accepts a beat, holds the result on the output until it
// is taken, and only then accepts the next beat. Words are never cleared; an
// entry only becomes readable once it has been written by a set or an insert.
module positional_list_buffer_core
	import plb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	// Input beats.
	input  logic             s_tvalid,
	output logic             s_tready,
	// s_tdata, low bit up: action [2:0], position [8:3], item_value [40:9], zero fill.
	input  logic [IN_W-1:0]  s_tdata,
	// Result beats.
	output logic             m_tvalid,
	input  logic             m_tready,
	// m_tdata, low bit up: ok [0], read_value [32:1], length [38:33], zero fill.
	output logic [OUT_W-1:0] m_tdata
);

	cmd_t              cmd;
	status_t           status;
	logic [ACT_W-1:0]  action;
	logic [POS_W-1:0]  position;
	logic [ITEM_W-1:0] item_value;
	logic              ok;
	logic [ITEM_W-1:0] read_value;
	logic [POS_W-1:0]  length;

	assign action     = s_tdata[ACT_W-1:0];
	assign position   = s_tdata[ACT_W+POS_W-1:ACT_W];
	assign item_value = s_tdata[ACT_W+POS_W+ITEM_W-1:ACT_W+POS_W];

	// The controller decodes the action against the position checks and
	// sequences the handshake on both sides.
	plb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.action    (action),
		.out_ready (m_tready),
		.status    (status),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.cmd       (cmd)
	);

	// The datapath holds the entry row, the length and the result register.
	plb_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.position   (position),
		.item_value (item_value),
		.status     (status),
		.ok         (ok),
		.read_value (read_value),
		.length     (length)
	);

	assign m_tdata = {(OUT_W - 1 - ITEM_W - POS_W)'(0), length, read_value, ok};

endmodule
